/* rtl/core/bitplane_tile_decoder_top_defines.svh */
// Shared assertion macros for the tile decoder.
`ifndef BITPLANE_TILE_DECODER_TOP_DEFINES_SVH
`define BITPLANE_TILE_DECODER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tbd_pkg.sv */
package tbd_pkg;

  localparam int TILE_BYTES_MAX = 64;
  localparam int ROW_BYTES      = 8;
  localparam int NUM_ROWS       = TILE_BYTES_MAX / ROW_BYTES;
  localparam int ADDR_W         = $clog2(TILE_BYTES_MAX);
  localparam int ROW_W          = $clog2(NUM_ROWS);
  localparam int CNT_W          = ADDR_W + 1;

  // One RAM row: eight bytes, lane 0 first. Also used for one pixel row.
  typedef logic [ROW_BYTES-1:0][7:0] row_t;

  typedef enum logic [3:0] {
    CODEC_LIN1       = 4'd0,
    CODEC_SEP2       = 4'd1,
    CODEC_INTL2      = 4'd2,
    CODEC_PLANAR3    = 4'd3,
    CODEC_INTL4      = 4'd4,
    CODEC_LIN4LO     = 4'd5,
    CODEC_LIN4HI     = 4'd6,
    CODEC_ROWPLANES4 = 4'd7,
    CODEC_LIN8       = 4'd8
  } codec_e;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_EMIT
  } state_e;

  // Control for the row unpacker.
  typedef struct packed {
    logic [3:0]       codec;
    logic             tile_ok;
    logic [ROW_W-1:0] row;
  } dec_ctrl_t;

endpackage

/* rtl/core/tbd_if.sv */
interface tbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       tile_end;

  modport source (output valid, output data_byte, output tile_end, input ready);
  modport sink (input valid, input data_byte, input tile_end, output ready);
endinterface

interface tbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_0;
  logic [7:0] pixel_1;
  logic [7:0] pixel_2;
  logic [7:0] pixel_3;
  logic [7:0] pixel_4;
  logic [7:0] pixel_5;
  logic [7:0] pixel_6;
  logic [7:0] pixel_7;
  logic [2:0] row_number;
  logic       last_row;

  modport source (output valid, output pixel_0, output pixel_1, output pixel_2,
                  output pixel_3, output pixel_4, output pixel_5, output pixel_6,
                  output pixel_7, output row_number, output last_row, input ready);
  modport sink (input valid, input pixel_0, input pixel_1, input pixel_2,
                input pixel_3, input pixel_4, input pixel_5, input pixel_6,
                input pixel_7, input row_number, input last_row, output ready);
endinterface

interface tbd_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] codec_select;

  modport source (output valid, output codec_select, input ready);
  modport sink (input valid, input codec_select, output ready);
endinterface

/* rtl/core/tbd_tile_ram.sv */
module tbd_tile_ram import tbd_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ROW_W-1:0]  rd_row_i,
  output row_t              rd_data_o
);

  // Byte-wide write, row-wide read.
  row_t mem_q [NUM_ROWS];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i[ADDR_W-1:ADDR_W-ROW_W]][wr_addr_i[ADDR_W-ROW_W-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/tbd_row_unpack.sv */
module tbd_row_unpack import tbd_pkg::*; (
  input  dec_ctrl_t ctrl_i,
  input  row_t      row_a_i,
  input  row_t      row_b_i,
  output row_t      pix_o
);

  function automatic row_t planes(input logic [7:0] p0, input logic [7:0] p1,
                                  input logic [7:0] p2, input logic [7:0] p3);
    row_t px;
    px = '0;
    for (int x = 0; x < ROW_BYTES; x++) begin
      px[x] = {4'b0000, p3[7-x], p2[7-x], p1[7-x], p0[7-x]};
    end
    return px;
  endfunction

  logic [2:0] r;
  logic [2:0] lane_even;
  logic [2:0] lane_odd;
  logic [7:0] nib_byte;
  row_t       pix;

  assign r         = ctrl_i.row;
  assign lane_even = {r[1:0], 1'b0};
  assign lane_odd  = {r[1:0], 1'b1};

  always_comb begin
    pix      = '0;
    nib_byte = '0;
    case (codec_e'(ctrl_i.codec))
      CODEC_LIN1:    pix = planes(row_a_i[r], 8'h00, 8'h00, 8'h00);
      CODEC_SEP2:    pix = planes(row_a_i[r], row_b_i[r], 8'h00, 8'h00);
      CODEC_INTL2:   pix = planes(row_a_i[lane_even], row_a_i[lane_odd], 8'h00, 8'h00);
      CODEC_PLANAR3: pix = planes(row_a_i[lane_even], row_a_i[lane_odd], row_b_i[r], 8'h00);
      CODEC_INTL4: begin
        pix = planes(row_a_i[lane_even], row_a_i[lane_odd],
                     row_b_i[lane_even], row_b_i[lane_odd]);
      end
      CODEC_LIN4LO: begin
        for (int c = 0; c < 4; c++) begin
          nib_byte     = row_a_i[{r[0], c[1:0]}];
          pix[2*c]     = {4'b0000, nib_byte[3:0]};
          pix[2*c + 1] = {4'b0000, nib_byte[7:4]};
        end
      end
      CODEC_LIN4HI: begin
        for (int c = 0; c < 4; c++) begin
          nib_byte     = row_a_i[{r[0], c[1:0]}];
          pix[2*c]     = {4'b0000, nib_byte[7:4]};
          pix[2*c + 1] = {4'b0000, nib_byte[3:0]};
        end
      end
      CODEC_ROWPLANES4: begin
        pix = planes(row_a_i[{r[0], 2'd0}], row_a_i[{r[0], 2'd1}],
                     row_a_i[{r[0], 2'd2}], row_a_i[{r[0], 2'd3}]);
      end
      CODEC_LIN8:    pix = row_a_i;
      default:       pix = '0;
    endcase
  end

  // Short tile or unknown codec: zero indices.
  assign pix_o = ctrl_i.tile_ok ? pix : '0;

endmodule

/* rtl/core/bitplane_tile_decoder_top.sv */
// Channel   Dir  Payload                              Request moves
// tile_in   in   data_byte[7:0], tile_end             one raw tile byte
// row_out   out  pixel_0..pixel_7[7:0], row_number,   one decoded pixel row
//                last_row
// cfg_wr    in   codec_select[3:0]                    one codec register write
//
// Flow: one byte per cycle while filling. The tile_end byte starts a decode
// that steps through read RAM row A, read RAM row B and emit for each row, with
// emit held by output stalls; the single read port of the tile RAM sets these steps.
// Reset: rst_ni clears the byte count, the FSM, the codec register and the
// output valid; the tile RAM is not cleared. A stalled row_out holds the FSM
// in emit; tile_in is not ready again until the eighth row is registered.
module bitplane_tile_decoder_top import tbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tbd_in_if.sink    tile_in,
  tbd_out_if.source row_out,
  tbd_cfg_if.sink   cfg_wr
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [3:0]       codec_select_q;
  logic [3:0]       codec_act_q;
  logic             tile_ok_q;
  row_t             row_a_q;

  logic             out_valid_q;
  row_t             out_pix_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_last_q;

  logic             in_fire;
  logic             room;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] need;
  logic             out_free;
  logic             emit;
  logic             rd_en;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] a_row;
  logic [ROW_W-1:0] b_row;
  row_t             rd_data;
  row_t             pix;
  dec_ctrl_t        dec_ctrl;

  // Config: always ready; the new codec is picked up at the next tile end.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_select_q <= '0;
    end else if (cfg_wr.valid) begin
      codec_select_q <= cfg_wr.codec_select;
    end
  end

  assign tile_in.ready = (state_q == ST_FILL);
  assign in_fire       = tile_in.valid && tile_in.ready;
  assign room          = (count_q < CNT_W'(TILE_BYTES_MAX));
  assign cnt_after     = room ? count_q + CNT_W'(1) : count_q;

  // Tile size in bytes per codec; zero marks an unknown codec.
  always_comb begin
    case (codec_e'(codec_select_q))
      CODEC_LIN1:       need = CNT_W'(8);
      CODEC_SEP2:       need = CNT_W'(16);
      CODEC_INTL2:      need = CNT_W'(16);
      CODEC_PLANAR3:    need = CNT_W'(24);
      CODEC_INTL4:      need = CNT_W'(32);
      CODEC_LIN4LO:     need = CNT_W'(32);
      CODEC_LIN4HI:     need = CNT_W'(32);
      CODEC_ROWPLANES4: need = CNT_W'(32);
      CODEC_LIN8:       need = CNT_W'(TILE_BYTES_MAX);
      default:          need = '0;
    endcase
  end

  // Which RAM rows hold the plane bytes of pixel row row_q.
  always_comb begin
    a_row = '0;
    b_row = '0;
    case (codec_e'(codec_act_q))
      CODEC_LIN1: begin
        a_row = '0;
        b_row = '0;
      end
      CODEC_SEP2: begin
        a_row = '0;
        b_row = ROW_W'(1);
      end
      CODEC_INTL2: begin
        a_row = {2'b00, row_q[2]};
        b_row = {2'b00, row_q[2]};
      end
      CODEC_PLANAR3: begin
        a_row = {2'b00, row_q[2]};
        b_row = ROW_W'(2);
      end
      CODEC_INTL4: begin
        a_row = {2'b00, row_q[2]};
        b_row = {2'b01, row_q[2]};
      end
      CODEC_LIN4LO, CODEC_LIN4HI, CODEC_ROWPLANES4: begin
        a_row = {1'b0, row_q[2:1]};
        b_row = {1'b0, row_q[2:1]};
      end
      CODEC_LIN8: begin
        a_row = row_q;
        b_row = row_q;
      end
      default: begin
        a_row = '0;
        b_row = '0;
      end
    endcase
  end

  assign rd_en  = (state_q == ST_RD_A) || (state_q == ST_RD_B);
  assign rd_row = (state_q == ST_RD_A) ? a_row : b_row;

  tbd_tile_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && room),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i (tile_in.data_byte),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (rd_data)
  );

  // Row A data lands during ST_RD_B; row B data stays on the RAM output in emit.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_B) begin
      row_a_q <= rd_data;
    end
  end

  assign dec_ctrl = '{codec: codec_act_q, tile_ok: tile_ok_q, row: row_q};

  tbd_row_unpack u_unpack (
    .ctrl_i  (dec_ctrl),
    .row_a_i (row_a_q),
    .row_b_i (rd_data),
    .pix_o   (pix)
  );

  assign out_free = !out_valid_q || row_out.ready;
  assign emit     = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    row_d   = row_q;
    case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          // Drop bytes beyond the store; the count saturates.
          count_d = cnt_after;
          if (tile_in.tile_end) begin
            count_d = '0;
            row_d   = '0;
            state_d = ST_RD_A;
          end
        end
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit) begin
          row_d   = row_q + ROW_W'(1);
          state_d = (row_q == ROW_W'(NUM_ROWS - 1)) ? ST_FILL : ST_RD_A;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // Latch the codec and the size check at tile end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_act_q <= '0;
      tile_ok_q   <= 1'b0;
    end else if (in_fire && tile_in.tile_end) begin
      codec_act_q <= codec_select_q;
      tile_ok_q   <= (need != '0) && (cnt_after >= need);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (row_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pix_q  <= pix;
      out_row_q  <= row_q;
      out_last_q <= (row_q == ROW_W'(NUM_ROWS - 1));
    end
  end

  assign row_out.valid      = out_valid_q;
  assign row_out.pixel_0    = out_pix_q[0];
  assign row_out.pixel_1    = out_pix_q[1];
  assign row_out.pixel_2    = out_pix_q[2];
  assign row_out.pixel_3    = out_pix_q[3];
  assign row_out.pixel_4    = out_pix_q[4];
  assign row_out.pixel_5    = out_pix_q[5];
  assign row_out.pixel_6    = out_pix_q[6];
  assign row_out.pixel_7    = out_pix_q[7];
  assign row_out.row_number = out_row_q;
  assign row_out.last_row   = out_last_q;

endmodule

/* rtl/core/tbd_checker.sv */
`include "bitplane_tile_decoder_top_defines.svh"

module tbd_checker import tbd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_tile_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_row_number_i,
  input logic       out_last_row_i
);

  `TBD_ASSERT_NEXT(a_stop_after_end, clk_i, rst_ni, in_valid_i && in_ready_i && in_tile_end_i, !in_ready_i, "input still ready after tile end")
  `TBD_ASSERT_SAME(a_last_is_row7, clk_i, rst_ni, out_valid_i && out_last_row_i, out_row_number_i == 3'd7, "last row flag on wrong row")
  `TBD_ASSERT_NEXT(a_row0_after_last, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_row_i, !out_valid_i || (out_row_number_i == 3'd0), "row after last row is not row zero")
  `TBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_row_number_i), "stalled row dropped or changed")

endmodule

bind bitplane_tile_decoder_top tbd_checker u_tbd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (tile_in.valid),
  .in_ready_i       (tile_in.ready),
  .in_tile_end_i    (tile_in.tile_end),
  .out_valid_i      (row_out.valid),
  .out_ready_i      (row_out.ready),
  .out_row_number_i (row_out.row_number),
  .out_last_row_i   (row_out.last_row)
);

/* test/tbd_row_checker.sv */
module tbd_row_checker import tbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tbd_in_if    tile_in,
  tbd_out_if   row_out,
  tbd_cfg_if   cfg_wr,
  output int   fail_count,
  output int   rows_pending,
  output int   rows_checked
);

  localparam int MAX_REPORTS = 10;
  // The third plane of the 3bpp format and the third and fourth planes of the
  // interleaved 4bpp format start here.
  localparam int UPPER_PLANE_BASE = 16;

  typedef struct packed {
    row_t             pixels;
    logic [ROW_W-1:0] row;
    logic             last;
  } pixel_row_t;

  logic [7:0]  tile_bytes [TILE_BYTES_MAX];
  int unsigned byte_count;
  logic [3:0]  codec_reg;
  pixel_row_t  row_q [$];

  function automatic int unsigned codec_bytes(logic [3:0] codec);
    case (codec)
      CODEC_LIN1:                    return 8;
      CODEC_SEP2, CODEC_INTL2:       return 16;
      CODEC_PLANAR3:                 return 24;
      CODEC_INTL4, CODEC_LIN4LO,
      CODEC_LIN4HI, CODEC_ROWPLANES4: return 32;
      CODEC_LIN8:                    return TILE_BYTES_MAX;
      default:                       return 0;
    endcase
  endfunction

  // Plane k gives index bit k; bit 7-x of each plane byte is pixel x.
  function automatic logic [7:0] plane_index(logic [7:0] p0, logic [7:0] p1,
                                             logic [7:0] p2, logic [7:0] p3, int x);
    int b;
    b = 7 - x;
    return {4'h0, p3[b], p2[b], p1[b], p0[b]};
  endfunction

  function automatic logic [7:0] pixel_index(int r, int x);
    logic [7:0] nibble_pair;
    case (codec_reg)
      CODEC_LIN1:
        return plane_index(tile_bytes[r], 8'h00, 8'h00, 8'h00, x);
      CODEC_SEP2:
        return plane_index(tile_bytes[r], tile_bytes[ROW_BYTES + r], 8'h00, 8'h00, x);
      CODEC_INTL2:
        return plane_index(tile_bytes[2*r], tile_bytes[2*r + 1], 8'h00, 8'h00, x);
      CODEC_PLANAR3:
        return plane_index(tile_bytes[2*r], tile_bytes[2*r + 1],
                           tile_bytes[UPPER_PLANE_BASE + r], 8'h00, x);
      CODEC_INTL4:
        return plane_index(tile_bytes[2*r], tile_bytes[2*r + 1],
                           tile_bytes[UPPER_PLANE_BASE + 2*r],
                           tile_bytes[UPPER_PLANE_BASE + 2*r + 1], x);
      CODEC_LIN4LO: begin
        nibble_pair = tile_bytes[4*r + x/2];
        return (x % 2) ? {4'h0, nibble_pair[7:4]} : {4'h0, nibble_pair[3:0]};
      end
      CODEC_LIN4HI: begin
        nibble_pair = tile_bytes[4*r + x/2];
        return (x % 2) ? {4'h0, nibble_pair[3:0]} : {4'h0, nibble_pair[7:4]};
      end
      CODEC_ROWPLANES4:
        return plane_index(tile_bytes[4*r], tile_bytes[4*r + 1],
                           tile_bytes[4*r + 2], tile_bytes[4*r + 3], x);
      CODEC_LIN8:
        return tile_bytes[ROW_BYTES*r + x];
      default:
        return 8'h00;
    endcase
  endfunction

  // Queue the eight rows of the tile just closed; short tiles and unknown
  // codecs decode to all-zero indices.
  task automatic predict_tile();
    pixel_row_t  exp_row;
    int unsigned need;
    logic        tile_ok;
    need    = codec_bytes(codec_reg);
    tile_ok = (need != 0) && (byte_count >= need);
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int x = 0; x < ROW_BYTES; x++) begin
        exp_row.pixels[x] = tile_ok ? pixel_index(r, x) : 8'h00;
      end
      exp_row.row  = ROW_W'(r);
      exp_row.last = (r == NUM_ROWS - 1);
      row_q.push_back(exp_row);
    end
    byte_count = 0;
  endtask

  task automatic check_row();
    pixel_row_t got, exp_row;
    got.pixels = {row_out.pixel_7, row_out.pixel_6, row_out.pixel_5, row_out.pixel_4,
                  row_out.pixel_3, row_out.pixel_2, row_out.pixel_1, row_out.pixel_0};
    got.row    = row_out.row_number;
    got.last   = row_out.last_row;
    rows_checked++;
    if (row_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected pixel row: row %0d last %0b pixels(7..0) %h",
                 got.row, got.last, got.pixels);
      return;
    end
    exp_row = row_q.pop_front();
    if (got !== exp_row) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("pixel row mismatch: expected row %0d last %0b pixels(7..0) %h, got row %0d last %0b pixels(7..0) %h",
                 exp_row.row, exp_row.last, exp_row.pixels, got.row, got.last, got.pixels);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_count   = 0;
      codec_reg    = CODEC_LIN1;
      row_q.delete();
      fail_count   = 0;
      rows_checked = 0;
      rows_pending = 0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) codec_reg = cfg_wr.codec_select;
      if (tile_in.valid && tile_in.ready) begin
        // Saturate: bytes past the store size are dropped.
        if (byte_count < TILE_BYTES_MAX) begin
          tile_bytes[byte_count] = tile_in.data_byte;
          byte_count++;
        end
        if (tile_in.tile_end) predict_tile();
      end
      if (row_out.valid && row_out.ready) check_row();
      rows_pending = row_q.size();
    end
  end

endmodule

/* test/bitplane_tile_decoder_top_tb.sv */
module bitplane_tile_decoder_top_tb;
  import tbd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 8;
  // Leave margin for the decode to finish after the last row.
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SEGMENTS      = 12;
  localparam int SEG_BYTES     = 8;

  // Codec values outside the defined set.
  localparam logic [3:0] CODEC_UNUSED_MIN = 4'd9;
  localparam logic [3:0] CODEC_UNUSED_MAX = 4'd15;

  // Idle mixes, cycled per segment: none, sender only, receiver only, both.
  localparam int SEND_IDLE_PCT [4] = '{0, 83, 0, 31};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 83, 31};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tbd_in_if  tile_in ();
  tbd_out_if row_out ();
  tbd_cfg_if cfg_wr ();

  int fail_count;
  int rows_pending;
  int rows_checked;

  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int tiles_sent     = 0;
  int bytes_sent     = 0;
  int codec_writes   = 0;

  // Walk every defined codec plus both unknown extremes; the last slot is
  // picked at random.
  logic [3:0] seg_codecs [SEGMENTS] = '{
    CODEC_LIN1, CODEC_SEP2, CODEC_INTL2, CODEC_PLANAR3, CODEC_INTL4, CODEC_LIN4LO,
    CODEC_LIN4HI, CODEC_ROWPLANES4, CODEC_LIN8, CODEC_UNUSED_MIN, CODEC_UNUSED_MAX,
    CODEC_LIN1
  };

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  bitplane_tile_decoder_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tile_in (tile_in),
    .row_out (row_out),
    .cfg_wr  (cfg_wr)
  );

  tbd_row_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tile_in      (tile_in),
    .row_out      (row_out),
    .cfg_wr       (cfg_wr),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  // Receiver side: stall the row output at the current rate, decided on the
  // falling edge so the block sees a stable ready at the rising edge.
  always @(negedge clk_i) begin
    row_out.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Tile size the codec expects; 0 for unknown codecs.
  function automatic int unsigned codec_bytes(logic [3:0] codec);
    case (codec)
      CODEC_LIN1:                    return 8;
      CODEC_SEP2, CODEC_INTL2:       return 16;
      CODEC_PLANAR3:                 return 24;
      CODEC_INTL4, CODEC_LIN4LO,
      CODEC_LIN4HI, CODEC_ROWPLANES4: return 32;
      CODEC_LIN8:                    return TILE_BYTES_MAX;
      default:                       return 0;
    endcase
  endfunction

  // Mostly exact-size tiles; the rest short, slightly long, or past the store.
  function automatic int unsigned tile_length(int unsigned need);
    int unsigned pick;
    pick = $urandom_range(99);
    if (need == 0)  return $urandom_range(16, 1);
    if (pick < 70)  return need;
    if (pick < 82)  return $urandom_range(need - 1, 1);
    if (pick < 94)  return need + $urandom_range(8, 1);
    return $urandom_range(TILE_BYTES_MAX + 8, TILE_BYTES_MAX + 1);
  endfunction

  // Send one request on tile_in. Called and returns on a falling edge; valid
  // stays high afterward so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] data, input logic last_b);
    while ($urandom_range(99) < send_idle_pct) begin
      tile_in.valid     = 1'b0;
      tile_in.data_byte = 8'($urandom);
      tile_in.tile_end  = 1'($urandom);
      @(negedge clk_i);
    end
    tile_in.valid     = 1'b1;
    tile_in.data_byte = data;
    tile_in.tile_end  = last_b;
    do @(posedge clk_i); while (!tile_in.ready);
    @(negedge clk_i);
    bytes_sent++;
    if (last_b) tiles_sent++;
  endtask

  task automatic send_tile(input int unsigned len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  // Hold the sender until every queued row has come back.
  task automatic wait_rows_drained();
    tile_in.valid = 1'b0;
    while (rows_pending != 0) @(negedge clk_i);
  endtask

  // Write the codec only with the block idle: drain rows, then let the
  // decoder finish before the write request.
  task automatic write_codec(input logic [3:0] codec);
    wait_rows_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_wr.valid        = 1'b1;
    cfg_wr.codec_select = codec;
    do @(posedge clk_i); while (!cfg_wr.ready);
    @(negedge clk_i);
    cfg_wr.valid = 1'b0;
    codec_writes++;
  endtask

  initial begin
    logic [7:0]  edge_bytes [8];
    logic [3:0]  codec;
    int unsigned seg_fill;
    int unsigned len;

    // Drive every input to a known value from time zero.
    tile_in.valid       = 1'b0;
    tile_in.data_byte   = 8'h00;
    tile_in.tile_end    = 1'b0;
    cfg_wr.valid        = 1'b0;
    cfg_wr.codec_select = CODEC_LIN1;
    row_out.ready       = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset codec (1bpp) with extreme and alternating bit patterns.
    edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    foreach (edge_bytes[i]) send_byte(edge_bytes[i], i == 7);
    // Short 1bpp tile: rows must come back all zero.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Highest unknown codec: zero rows regardless of data.
    write_codec(CODEC_UNUSED_MAX);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // 8bpp with a single byte, tile_end on the first byte.
    write_codec(CODEC_LIN8);
    send_byte(8'hFF, 1'b1);

    // Random segments: one codec each, idle mix rotating per segment.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      codec = (seg == SEGMENTS - 1) ? 4'($urandom_range(CODEC_LIN8)) : seg_codecs[seg];
      write_codec(codec);
      send_idle_pct  = SEND_IDLE_PCT[seg % 4];
      recv_stall_pct = RECV_STALL_PCT[seg % 4];
      seg_fill = 0;
      while (seg_fill < SEG_BYTES) begin
        // Now and then let the output side empty out before the next tile.
        if ($urandom_range(9) == 0) wait_rows_drained();
        len = tile_length(codec_bytes(codec));
        send_tile(len);
        seg_fill += len;
      end
    end

    // Drain and settle, then report.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_rows_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d tiles (%0d bytes), %0d rows checked, %0d codec writes.",
             tiles_sent, bytes_sent, rows_checked, codec_writes);
    $display("Tiles were exact, short, overlong and unknown-codec under four idle mixes.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* bitplane_tile_decoder_top.f */
+incdir+rtl/core
rtl/core/tbd_pkg.sv
rtl/core/tbd_if.sv
rtl/core/tbd_tile_ram.sv
rtl/core/tbd_row_unpack.sv
rtl/core/bitplane_tile_decoder_top.sv
rtl/core/tbd_checker.sv
test/tbd_row_checker.sv
test/bitplane_tile_decoder_top_tb.sv
